>>> src/ldt_pkg.sv
`timescale 1ns / 1ps
// Shared constants and width helpers for the linear detrend block.
// No dependencies; ldt_front, ldt_back and the top level import this package.
package ldt_pkg;

  localparam int MAX_LEN_DEF     = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // residual format: Q17.8
  localparam int RES_W  = 26;
  localparam int FRAC_W = 8;
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // two sample banks: one filling, one draining
  localparam int NUM_BANKS = 2;
  localparam int BANK_W    = 1;

  function automatic int cnt_w(input int max_len);
    return $clog2(max_len + 1);
  endfunction

  function automatic int idx_w(input int max_len);
    return $clog2(max_len);
  endfunction

  function automatic int sum_w(input int max_len, input int sample_bits);
    return sample_bits + idx_w(max_len) + 1;
  endfunction

  function automatic int wsum_w(input int max_len, input int sample_bits);
    return sample_bits + 2 * idx_w(max_len) + 1;
  endfunction

  // job descriptor: {bank, n, sum, weighted sum}
  function automatic int job_w(input int max_len, input int sample_bits);
    return BANK_W + cnt_w(max_len) + sum_w(max_len, sample_bits)
           + wsum_w(max_len, sample_bits);
  endfunction

endpackage

>>> src/ldt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ldt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/ldt_queue.sv
`timescale 1ns / 1ps
// Small FIFO of series job descriptors between the front and back ends.
// No package dependencies.
module ldt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [CNT_W-1:0] count;

  assign pop_data = slots[rp];
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue read while empty");

endmodule

>>> src/ldt_front.sv
`timescale 1ns / 1ps
// Front end: takes samples, writes them to the current bank, keeps the sum
// and time-weighted sum, and queues a job at series end. Uses ldt_pkg.
module ldt_front #(
  parameter int MAX_LEN     = ldt_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = ldt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          wr_en,
  output logic [ldt_pkg::BANK_W+ldt_pkg::idx_w(MAX_LEN)-1:0] wr_addr,
  output logic [SAMPLE_BITS-1:0]        wr_data,
  output logic                          job_push,
  output logic [ldt_pkg::job_w(MAX_LEN, SAMPLE_BITS)-1:0] job,
  input  logic                          ser_done
);

  import ldt_pkg::*;

  localparam int CW = cnt_w(MAX_LEN);
  localparam int IW = idx_w(MAX_LEN);
  localparam int SW = sum_w(MAX_LEN, SAMPLE_BITS);
  localparam int WW = wsum_w(MAX_LEN, SAMPLE_BITS);
  localparam int PW = $clog2(NUM_BANKS + 1);

  logic [CW-1:0]                cnt, cnt_inc;
  logic signed [SW-1:0]         ssum, ssum_next;
  logic signed [WW-1:0]         wsum, wsum_next;
  logic signed [SAMPLE_BITS+IW:0] tw;
  logic [BANK_W-1:0]            bank;
  logic [PW-1:0]                pend;
  logic                         acc, fin;

  // a series in flight per bank; stall once both banks are owned by the back end
  assign in_stall = (pend == PW'(NUM_BANKS));
  assign acc      = in_valid && !in_stall;

  assign cnt_inc   = cnt + 1'b1;
  assign tw        = $signed({1'b0, cnt[IW-1:0]}) * sample;
  assign ssum_next = ssum + SW'(sample);
  assign wsum_next = wsum + WW'(tw);
  assign fin       = last || (cnt_inc == CW'(MAX_LEN));

  assign wr_en    = acc;
  assign wr_addr  = {bank, cnt[IW-1:0]};
  assign wr_data  = sample;
  assign job_push = acc && fin;
  assign job      = {bank, cnt_inc, ssum_next, wsum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      ssum <= '0;
      wsum <= '0;
      bank <= '0;
      pend <= '0;
    end else begin
      if (acc) begin
        if (fin) begin
          cnt  <= '0;
          ssum <= '0;
          wsum <= '0;
          bank <= bank + 1'b1;
        end else begin
          cnt  <= cnt_inc;
          ssum <= ssum_next;
          wsum <= wsum_next;
        end
      end
      if (job_push && !ser_done) begin
        pend <= pend + 1'b1;
      end else if (ser_done && !job_push) begin
        pend <= pend - 1'b1;
      end
    end
  end

  a_done_has_job: assert property (@(posedge clk) disable iff (rst)
    ser_done |-> (pend != '0))
    else $error("series finished with no series pending");

endmodule

>>> src/ldt_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, with an up-front check
// for quotients that do not fit QUO_W bits. No package dependencies.
module ldt_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 21,
  parameter int QUO_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  localparam int HI_W   = NUM_W - QUO_W;
  localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  logic [CMP_W-1:0]  hi_ext, den_ext;
  logic [DEN_W-1:0]  rem, dsr;
  logic [QUO_W-1:0]  low;
  logic [DEN_W:0]    trial, trial_sub;
  logic [STEP_W-1:0] steps;
  logic              ge, too_big;

  assign hi_ext    = CMP_W'(num[NUM_W-1:QUO_W]);
  assign den_ext   = CMP_W'(den);
  // quotient >= 2^QUO_W exactly when the upper part is not below the divisor
  assign too_big   = (hi_ext >= den_ext);
  assign trial     = {rem, low[QUO_W-1]};
  assign ge        = (trial >= {1'b0, dsr});
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_W'(QUO_W);
        busy  <= !too_big;
        done  <= too_big;
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= den;
      low <= num[QUO_W-1:0];
      rem <= hi_ext[DEN_W-1:0];
      quo <= '0;
      ovf <= too_big;
    end else if (busy) begin
      rem <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[QUO_W-2:0], ge};
      low <= low << 1;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

>>> src/ldt_back.sv
`timescale 1ns / 1ps
// Back end: takes a series job, fits the line and emits one rounded,
// saturated residual per stored sample. Uses ldt_pkg and ldt_div.
module ldt_back #(
  parameter int MAX_LEN     = ldt_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = ldt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic [ldt_pkg::job_w(MAX_LEN, SAMPLE_BITS)-1:0] job,
  output logic [ldt_pkg::BANK_W+ldt_pkg::idx_w(MAX_LEN)-1:0] rd_addr,
  input  logic signed [SAMPLE_BITS-1:0]        rd_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ldt_pkg::RES_W-1:0]     residual,
  output logic                                 last_res,
  output logic                                 ser_done
);

  import ldt_pkg::*;

  localparam int CW   = cnt_w(MAX_LEN);
  localparam int IW   = idx_w(MAX_LEN);
  localparam int SW   = sum_w(MAX_LEN, SAMPLE_BITS);
  localparam int WW   = wsum_w(MAX_LEN, SAMPLE_BITS);
  localparam int N2W  = 2 * CW;
  localparam int DW   = 3 * CW;
  localparam int NMW  = SW + CW + 1;
  localparam int LW   = SAMPLE_BITS + IW + CW + 3;
  localparam int KW   = CW + 3;
  localparam int YDW  = SAMPLE_BITS + DW + 1;
  localparam int SNW  = SW + N2W + 1;
  localparam int LKW  = LW + KW;
  localparam int MW1  = (YDW > SNW) ? YDW : SNW;
  localparam int MW   = (MW1 > LKW) ? MW1 : LKW;
  localparam int DFW  = MW + 2;
  localparam int NW   = DFW + FRAC_W;

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STATE_W-1:0] S_PREP1 = 4'd1;
  localparam logic [STATE_W-1:0] S_PREP2 = 4'd2;
  localparam logic [STATE_W-1:0] S_PREP3 = 4'd3;
  localparam logic [STATE_W-1:0] S_READ  = 4'd4;
  localparam logic [STATE_W-1:0] S_MUL   = 4'd5;
  localparam logic [STATE_W-1:0] S_DIFF  = 4'd6;
  localparam logic [STATE_W-1:0] S_ABS   = 4'd7;
  localparam logic [STATE_W-1:0] S_START = 4'd8;
  localparam logic [STATE_W-1:0] S_DIV   = 4'd9;
  localparam logic [STATE_W-1:0] S_OUT   = 4'd10;

  logic [STATE_W-1:0] state, state_next;

  logic [BANK_W-1:0]     j_bank, bank;
  logic [CW-1:0]         j_n, n;
  logic signed [SW-1:0]  j_sum, ssum;
  logic signed [WW-1:0]  j_wsum, wsum;
  logic                  one;

  logic [N2W-1:0]         nn1;
  logic signed [NMW-1:0]  nm1s;
  logic [DW-1:0]          dd;
  logic signed [LW-1:0]   lin;
  logic signed [SNW-1:0]  snn;
  logic [IW-1:0]          t;
  logic signed [KW-1:0]   kv, k3;
  logic signed [YDW-1:0]  ydd;
  logic signed [LKW-1:0]  lk3;
  logic signed [DFW-1:0]  diff;
  logic [DFW-1:0]         absd;
  logic                   neg;

  logic                   div_start, div_busy, div_done, div_ovf, big;
  logic [NW-1:0]          div_num;
  logic [RES_W-1:0]       div_q;
  logic signed [RES_W-1:0] sat_val;
  logic                   xfer;

  assign {j_bank, j_n, j_sum, j_wsum} = job;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign rd_addr  = {bank, t};
  assign xfer     = out_valid && !out_stall;
  assign ser_done = xfer && last_res;

  // time offset 2t - n + 1, times 3
  assign kv = KW'($signed({1'b0, t, 1'b0})) - KW'($signed({1'b0, n})) + KW'(1);
  assign k3 = (kv <<< 1) + kv;

  // residual * 256 * D, rounded: add D/2 to the magnitude before dividing
  assign div_start = (state == S_START);
  assign div_num   = {absd, {FRAC_W{1'b0}}} + NW'(dd >> 1);

  assign big     = div_ovf || div_q[RES_W-1];
  assign sat_val = neg ? RES_MIN : RES_MAX;

  ldt_div #(
    .NUM_W (NW),
    .DEN_W (DW),
    .QUO_W (RES_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dd),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_q),
    .ovf   (div_ovf)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!q_empty) state_next = S_PREP1;
      S_PREP1: state_next = S_PREP2;
      S_PREP2: state_next = S_PREP3;
      S_PREP3: state_next = S_READ;
      S_READ:  state_next = S_MUL;
      S_MUL:   state_next = S_DIFF;
      S_DIFF:  state_next = S_ABS;
      S_ABS:   state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV:   if (div_done) state_next = S_OUT;
      S_OUT: begin
        if (xfer) begin
          state_next = last_res ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      t         <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV && div_done) begin
        out_valid <= 1'b1;
      end else if (xfer) begin
        out_valid <= 1'b0;
      end
      if (state == S_PREP3) begin
        t <= '0;
      end else if (xfer && !last_res) begin
        t <= t + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        bank <= j_bank;
        n    <= j_n;
        ssum <= j_sum;
        wsum <= j_wsum;
        one  <= (j_n == CW'(1));
      end
      S_PREP1: begin
        nn1  <= n * n - 1'b1;
        nm1s <= $signed({1'b0, n - 1'b1}) * ssum;
      end
      S_PREP2: begin
        dd  <= n * nn1;
        lin <= (LW'(wsum) <<< 1) - LW'(nm1s);
      end
      S_PREP3: snn <= ssum * $signed({1'b0, nn1});
      S_MUL: begin
        ydd <= rd_data * $signed({1'b0, dd});
        lk3 <= lin * k3;
      end
      S_DIFF: diff <= DFW'(ydd) - DFW'(snn) - DFW'(lk3);
      S_ABS: begin
        neg  <= diff[DFW-1];
        absd <= diff[DFW-1] ? $unsigned(-diff) : $unsigned(diff);
      end
      S_DIV: begin
        if (div_done) begin
          if (one) begin
            residual <= '0;
          end else if (big) begin
            residual <= sat_val;
          end else begin
            residual <= neg ? $signed(-div_q) : $signed(div_q);
          end
          last_res <= (CW'(t) == n - 1'b1);
        end
      end
      default: ;
    endcase
  end

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> out_valid)
    else $error("residual state without a valid result");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide state");
  a_div_busy_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_DIV))
    else $error("divider running outside the divide state");

endmodule

>>> src/linear_detrend_series.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  sample, last
// output    out        out_valid/out_stall  residual, last_res
//
// Samples are taken one per cycle into one of two sample banks; the front
// end stalls only while both banks hold series awaiting residuals.
// Each residual passes through the 26-step restoring divider, and each series
// first runs its setup states; the next series loads meanwhile.
// rst is synchronous, active high, and clears all control state.
// A stall on the output holds the residual and pauses the back end only.
// Top level of the least-squares linear detrend block. Uses ldt_pkg,
// ldt_front, ldt_ram, ldt_queue and ldt_back.
module linear_detrend_series #(
  parameter int MAX_LEN     = ldt_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = ldt_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [SAMPLE_BITS-1:0]    sample,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [ldt_pkg::RES_W-1:0] residual,
  output logic                             last_res
);

  import ldt_pkg::*;

  localparam int AW = BANK_W + idx_w(MAX_LEN);
  localparam int JW = job_w(MAX_LEN, SAMPLE_BITS);

  logic                   wr_en;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] wr_data, rd_raw;
  logic                   job_push, q_pop, q_empty, q_full;
  logic [JW-1:0]          job_in, job_out;
  logic                   ser_done;

  ldt_front #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .last     (last),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job_push (job_push),
    .job      (job_in),
    .ser_done (ser_done)
  );

  ldt_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  ldt_queue #(
    .WIDTH (JW),
    .DEPTH (NUM_BANKS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .pop       (q_pop),
    .pop_data  (job_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  ldt_back #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .job       (job_out),
    .rd_addr   (rd_addr),
    .rd_data   ($signed(rd_raw)),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .residual  (residual),
    .last_res  (last_res),
    .ser_done  (ser_done)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) job_push |-> !q_full)
    else $error("series ended with no free job slot");

endmodule
